>>> rtl/core/fupc_pkg.sv
// Package for the firmware update packet checker core.
// Types, constants and result codes shared by all rtl/core files; no dependencies.
package fupc_pkg;

    localparam int STORE_BYTES    = 40;
    localparam int MAX_DATA_BYTES = 32;
    localparam int STORE_AW       = $clog2(STORE_BYTES);
    localparam int QUEUE_DEPTH    = 2;

    // byte offsets inside a packet
    localparam int ADDR_OFS = 1;
    localparam int SIZE_OFS = 2;
    localparam int CNT_OFS  = 5;
    localparam int DATA_OFS = 6;
    localparam int WAIT_OFS = 6;

    localparam logic [7:0]  START_CMD      = 8'hAA;
    localparam logic [7:0]  START_LEN      = 8'd10;
    localparam logic [7:0]  HDR_LEN        = 8'd7;
    localparam logic [23:0] APP_START_RST  = 24'd4096;
    localparam logic [24:0] FLASH_SIZE_RST = 25'h0040000;

    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [3:0] {
        CODE_START_OK   = 4'd0,
        CODE_START_BAD  = 4'd1,
        CODE_BOOT_APP   = 4'd2,
        CODE_PROGRAMMED = 4'd3,
        CODE_NACK_CSUM  = 4'd4,
        CODE_NACK_LEN   = 4'd5,
        CODE_NACK_GAP   = 4'd6,
        CODE_DUPLICATE  = 4'd7,
        CODE_BAD_LEN    = 4'd8,
        CODE_DONE       = 4'd9,
        CODE_TOO_LARGE  = 4'd10,
        CODE_TMO_IGN    = 4'd11,
        CODE_HALTED     = 4'd12
    } code_t;

    typedef enum logic {
        CFG_APP_START  = 1'b0,
        CFG_FLASH_SIZE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        JOB_HALTED  = 2'd0,
        JOB_TIMEOUT = 2'd1,
        JOB_PACKET  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  len;
        logic [15:0] sum;
    } job_t;

    typedef struct packed {
        logic idle;
        logic halted;
    } status_t;

endpackage

>>> rtl/core/fupc_ifs.sv
// Channel interfaces of the firmware update packet checker core.
// Input byte channel, result channel and configuration write channel; uses fupc_pkg.
interface fupc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface fupc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  code;
    logic [31:0] address;
    logic [31:0] data_word;
    logic [31:0] wait_time;
    logic        last;

    modport source (output valid, output kind, output code, output address,
                    output data_word, output wait_time, output last, input ready);
    modport sink   (input valid, input kind, input code, input address,
                    input data_word, input wait_time, input last, output ready);
endinterface

interface fupc_cfg_if;
    logic                valid;
    logic                ready;
    fupc_pkg::cfg_idx_t  index;
    logic [24:0]         wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/fupc_queue.sv
// Short job queue between the front and back end of the packet checker.
// Holds fupc_pkg::job_t entries; uses fupc_pkg.
module fupc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fupc_pkg::job_t din,
    input  logic           pop,
    output fupc_pkg::job_t dout,
    output logic           empty,
    output logic           full
);

    localparam int QPW = (fupc_pkg::QUEUE_DEPTH > 1) ? $clog2(fupc_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(fupc_pkg::QUEUE_DEPTH + 1);

    fupc_pkg::job_t   entry_reg [fupc_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCW'(fupc_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(fupc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(fupc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/core/fupc_front.sv
// Front end of the packet checker: takes input beats, tracks packet framing,
// fills the packet store and queues one job per beat that needs a verdict. Uses fupc_pkg.
module fupc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    fupc_in_if.sink                         rx,
    input  fupc_pkg::status_t               st,
    input  logic                            q_empty,
    output logic                            q_push,
    output fupc_pkg::job_t                  q_din,
    input  logic [fupc_pkg::STORE_AW-1:0]   rd_addr,
    output logic [7:0]                      rd_data
);

    localparam int AW = fupc_pkg::STORE_AW;

    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  pkt_len_reg, pkt_len_next;
    logic [15:0] run_sum_reg, run_sum_next;
    logic [7:0]  store_mem [fupc_pkg::STORE_BYTES];
    logic [7:0]  rd_data_reg;
    logic        we;
    logic [AW-1:0] wa;
    logic        accept;

    // back end must be idle so the store is not overwritten under it
    assign rx.ready = st.idle && q_empty;
    assign accept   = rx.valid && rx.ready;
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        pkt_len_next    = pkt_len_reg;
        run_sum_next    = run_sum_reg;
        q_push          = 1'b0;
        q_din.kind      = fupc_pkg::JOB_PACKET;
        q_din.len       = pkt_len_reg;
        q_din.sum       = run_sum_reg;
        we              = 1'b0;
        wa              = '0;
        if (accept)
        begin
            if (st.halted)
            begin
                byte_index_next = '0;
                q_push          = 1'b1;
                q_din.kind      = fupc_pkg::JOB_HALTED;
            end
            else if (rx.op)
            begin
                // partial packet is dropped
                byte_index_next = '0;
                q_push          = 1'b1;
                q_din.kind      = fupc_pkg::JOB_TIMEOUT;
            end
            else if (byte_index_reg == '0)
            begin
                pkt_len_next = rx.data_byte;
                run_sum_next = '0;
                we           = 1'b1;
                q_din.len    = rx.data_byte;
                q_din.sum    = '0;
                if (rx.data_byte == '0)
                begin
                    q_push = 1'b1;
                end
                else
                begin
                    byte_index_next = 8'd1;
                end
            end
            else
            begin
                run_sum_next = run_sum_reg + {8'b0, rx.data_byte};
                q_din.sum    = run_sum_next;
                if ({1'b0, byte_index_reg} < 9'(fupc_pkg::STORE_BYTES))
                begin
                    we = 1'b1;
                    wa = byte_index_reg[AW-1:0];
                end
                if (byte_index_reg == pkt_len_reg)
                begin
                    q_push          = 1'b1;
                    byte_index_next = '0;
                end
                else
                begin
                    byte_index_next = byte_index_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            pkt_len_reg    <= '0;
            run_sum_reg    <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            pkt_len_reg    <= pkt_len_next;
            run_sum_reg    <= run_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= rx.data_byte;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

endmodule

>>> rtl/core/fupc_back.sv
// Back end of the packet checker: pops jobs, reads the packet store one byte a
// cycle, judges packets, owns phase and address state, drives the result register.
// Uses fupc_pkg and the channel interfaces.
module fupc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    fupc_out_if.source                      res,
    fupc_cfg_if.sink                        cfg,
    input  logic                            q_empty,
    input  fupc_pkg::job_t                  q_dout,
    output logic                            q_pop,
    output fupc_pkg::status_t               st,
    output logic [fupc_pkg::STORE_AW-1:0]   rd_addr,
    input  logic [7:0]                      rd_data
);

    localparam int AW = fupc_pkg::STORE_AW;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_FETCH   = 12'b0000_0000_0010,
        S_ST_CMD  = 12'b0000_0000_0100,
        S_ST_SIZE = 12'b0000_0000_1000,
        S_ST_WAIT = 12'b0000_0001_0000,
        S_ST_DONE = 12'b0000_0010_0000,
        S_PG_ADDR = 12'b0000_0100_0000,
        S_PG_CNT  = 12'b0000_1000_0000,
        S_PG_CSUM = 12'b0001_0000_0000,
        S_PG_NEXT = 12'b0010_0000_0000,
        S_PG_WORD = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_START   = 3'b001,
        PH_PROGRAM = 3'b010,
        PH_HALT    = 3'b100
    } phase_t;

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    state_t        nxt_reg, nxt_next;
    phase_t        phase_reg, phase_next;

    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [2:0]    remain_reg, remain_next;
    logic          pend_reg, pend_next;
    logic          le_reg, le_next;
    logic [31:0]   sh_reg, sh_next;

    logic [7:0]    job_len_reg, job_len_next;
    logic [15:0]   job_sum_reg, job_sum_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   wait_reg, wait_next;
    logic [31:0]   end_reg, end_next;
    logic [31:0]   exp_reg, exp_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [7:0]    k_reg, k_next;
    logic [23:0]   app_start_reg, app_start_next;
    logic [24:0]   flash_size_reg, flash_size_next;

    logic          res_kind_reg, res_kind_next;
    logic [3:0]    res_code_reg, res_code_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [31:0]   res_word_reg, res_word_next;
    logic [31:0]   res_wait_reg, res_wait_next;
    logic          res_last_reg, res_last_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic [3:0]    out_code_reg, out_code_next;
    logic [31:0]   out_addr_reg, out_addr_next;
    logic [31:0]   out_word_reg, out_word_next;
    logic [31:0]   out_wait_reg, out_wait_next;
    logic          out_last_reg, out_last_next;

    // fetch and emit requests from the state decode
    logic          fetch_go;
    logic [AW-1:0] fetch_addr;
    logic [2:0]    fetch_n;
    logic          fetch_le;
    state_t        fetch_ret;
    logic          emit_go;
    logic          emit_kind;
    fupc_pkg::code_t emit_code;
    logic [31:0]   emit_addr;
    logic [31:0]   emit_word;
    logic [31:0]   emit_wait;
    logic          emit_last;
    state_t        emit_nxt;

    logic          out_free;
    logic [32:0]   end_sum;
    logic [31:0]   exp_sum;
    logic [15:0]   csum;
    logic          cnt_bad;

    assign out_free   = !out_valid_reg || res.ready;
    assign end_sum    = {9'b0, app_start_reg} + {1'b0, size_reg};
    assign exp_sum    = exp_reg + {24'b0, cnt_reg};
    assign csum       = job_sum_reg - {8'b0, sh_reg[15:8]} - {8'b0, sh_reg[7:0]} + sh_reg[15:0];
    assign cnt_bad    = (cnt_reg[1:0] != 2'b00) || (cnt_reg > 8'(fupc_pkg::MAX_DATA_BYTES))
                        || (cnt_reg > (job_len_reg - fupc_pkg::HDR_LEN));

    assign st.idle    = (state_reg == S_IDLE);
    assign st.halted  = (phase_reg == PH_HALT);
    assign rd_addr    = rd_addr_reg;
    assign cfg.ready  = 1'b1;

    assign res.valid     = out_valid_reg;
    assign res.kind      = out_kind_reg;
    assign res.code      = out_code_reg;
    assign res.address   = out_addr_reg;
    assign res.data_word = out_word_reg;
    assign res.wait_time = out_wait_reg;
    assign res.last      = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        nxt_next        = nxt_reg;
        phase_next      = phase_reg;
        rd_addr_next    = rd_addr_reg;
        remain_next     = remain_reg;
        pend_next       = pend_reg;
        le_next         = le_reg;
        sh_next         = sh_reg;
        job_len_next    = job_len_reg;
        job_sum_next    = job_sum_reg;
        size_next       = size_reg;
        wait_next       = wait_reg;
        end_next        = end_reg;
        exp_next        = exp_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        app_start_next  = app_start_reg;
        flash_size_next = flash_size_reg;
        res_kind_next   = res_kind_reg;
        res_code_next   = res_code_reg;
        res_addr_next   = res_addr_reg;
        res_word_next   = res_word_reg;
        res_wait_next   = res_wait_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_code_next   = out_code_reg;
        out_addr_next   = out_addr_reg;
        out_word_next   = out_word_reg;
        out_wait_next   = out_wait_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;

        fetch_go   = 1'b0;
        fetch_addr = '0;
        fetch_n    = 3'd1;
        fetch_le   = 1'b0;
        fetch_ret  = S_IDLE;
        emit_go    = 1'b0;
        emit_kind  = fupc_pkg::KIND_VERDICT;
        emit_code  = fupc_pkg::CODE_HALTED;
        emit_addr  = '0;
        emit_word  = '0;
        emit_wait  = '0;
        emit_last  = 1'b1;
        emit_nxt   = S_IDLE;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                fupc_pkg::CFG_APP_START:  app_start_next  = cfg.wdata[23:0];
                fupc_pkg::CFG_FLASH_SIZE: flash_size_next = cfg.wdata;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    job_len_next = q_dout.len;
                    job_sum_next = q_dout.sum;
                    unique case (q_dout.kind)
                        fupc_pkg::JOB_TIMEOUT:
                        begin
                            emit_go = 1'b1;
                            if (phase_reg == PH_START)
                            begin
                                phase_next = PH_HALT;
                                emit_code  = fupc_pkg::CODE_BOOT_APP;
                            end
                            else
                            begin
                                emit_code = fupc_pkg::CODE_TMO_IGN;
                            end
                        end
                        fupc_pkg::JOB_PACKET:
                        begin
                            if (phase_reg == PH_START)
                            begin
                                if (q_dout.len == '0)
                                begin
                                    // empty start packet acts as a timeout
                                    phase_next = PH_HALT;
                                    emit_go    = 1'b1;
                                    emit_code  = fupc_pkg::CODE_BOOT_APP;
                                end
                                else if (q_dout.len == fupc_pkg::START_LEN)
                                begin
                                    fetch_go   = 1'b1;
                                    fetch_addr = AW'(fupc_pkg::ADDR_OFS);
                                    fetch_n    = 3'd1;
                                    fetch_ret  = S_ST_CMD;
                                end
                                else
                                begin
                                    phase_next = PH_HALT;
                                    emit_go    = 1'b1;
                                    emit_code  = fupc_pkg::CODE_START_BAD;
                                end
                            end
                            else if ((q_dout.len > fupc_pkg::HDR_LEN) &&
                                     ({1'b0, q_dout.len} < 9'(fupc_pkg::STORE_BYTES)))
                            begin
                                fetch_go   = 1'b1;
                                fetch_addr = AW'(fupc_pkg::ADDR_OFS);
                                fetch_n    = 3'd4;
                                fetch_ret  = S_PG_ADDR;
                            end
                            else
                            begin
                                emit_go   = 1'b1;
                                emit_code = fupc_pkg::CODE_BAD_LEN;
                            end
                        end
                        default:
                        begin
                            emit_go   = 1'b1;
                            emit_code = fupc_pkg::CODE_HALTED;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // read data arrives in the cycle after its address
                if (pend_reg)
                begin
                    sh_next = le_reg ? {rd_data, sh_reg[31:8]} : {sh_reg[23:0], rd_data};
                end
                if (remain_reg != 3'd0)
                begin
                    rd_addr_next = rd_addr_reg + 1'b1;
                    remain_next  = remain_reg - 3'd1;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ret_reg;
                end
            end
            S_ST_CMD:
            begin
                if ((sh_reg[7:0] == fupc_pkg::START_CMD) && (job_sum_reg[7:0] == 8'd0))
                begin
                    fetch_go   = 1'b1;
                    fetch_addr = AW'(fupc_pkg::SIZE_OFS);
                    fetch_n    = 3'd4;
                    fetch_ret  = S_ST_SIZE;
                end
                else
                begin
                    phase_next = PH_HALT;
                    emit_go    = 1'b1;
                    emit_code  = fupc_pkg::CODE_START_BAD;
                end
            end
            S_ST_SIZE:
            begin
                size_next  = sh_reg;
                fetch_go   = 1'b1;
                fetch_addr = AW'(fupc_pkg::WAIT_OFS);
                fetch_n    = 3'd4;
                fetch_ret  = S_ST_WAIT;
            end
            S_ST_WAIT:
            begin
                wait_next = sh_reg;
                emit_go   = 1'b1;
                emit_addr = size_reg;
                emit_wait = sh_reg;
                if (end_sum > {8'b0, flash_size_reg})
                begin
                    phase_next = PH_HALT;
                    emit_code  = fupc_pkg::CODE_TOO_LARGE;
                end
                else
                begin
                    end_next  = end_sum[31:0];
                    exp_next  = {8'b0, app_start_reg};
                    emit_code = fupc_pkg::CODE_START_OK;
                    if (size_reg == '0)
                    begin
                        // empty image: done right after the start verdict
                        emit_last = 1'b0;
                        emit_nxt  = S_ST_DONE;
                    end
                    else
                    begin
                        phase_next = PH_PROGRAM;
                    end
                end
            end
            S_ST_DONE:
            begin
                phase_next = PH_HALT;
                emit_go    = 1'b1;
                emit_code  = fupc_pkg::CODE_DONE;
            end
            S_PG_ADDR:
            begin
                if (sh_reg > exp_reg)
                begin
                    emit_go   = 1'b1;
                    emit_code = fupc_pkg::CODE_NACK_GAP;
                end
                else if (sh_reg < exp_reg)
                begin
                    emit_go   = 1'b1;
                    emit_code = fupc_pkg::CODE_DUPLICATE;
                end
                else
                begin
                    fetch_go   = 1'b1;
                    fetch_addr = AW'(fupc_pkg::CNT_OFS);
                    fetch_n    = 3'd1;
                    fetch_ret  = S_PG_CNT;
                end
            end
            S_PG_CNT:
            begin
                cnt_next   = sh_reg[7:0];
                fetch_go   = 1'b1;
                fetch_addr = job_len_reg[AW-1:0] - AW'(1);
                fetch_n    = 3'd2;
                fetch_ret  = S_PG_CSUM;
            end
            S_PG_CSUM:
            begin
                if (csum != 16'd0)
                begin
                    emit_go   = 1'b1;
                    emit_code = fupc_pkg::CODE_NACK_CSUM;
                end
                else if (cnt_bad)
                begin
                    emit_go   = 1'b1;
                    emit_code = fupc_pkg::CODE_NACK_LEN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_PG_NEXT;
                end
            end
            S_PG_NEXT:
            begin
                if (k_reg < cnt_reg)
                begin
                    fetch_go   = 1'b1;
                    fetch_addr = AW'(k_reg) + AW'(fupc_pkg::DATA_OFS);
                    fetch_n    = 3'd4;
                    fetch_le   = 1'b1;
                    fetch_ret  = S_PG_WORD;
                end
                else
                begin
                    exp_next = exp_sum;
                    emit_go  = 1'b1;
                    if (exp_sum >= end_reg)
                    begin
                        phase_next = PH_HALT;
                        emit_code  = fupc_pkg::CODE_DONE;
                    end
                    else
                    begin
                        emit_code = fupc_pkg::CODE_PROGRAMMED;
                    end
                end
            end
            S_PG_WORD:
            begin
                k_next    = k_reg + 8'd4;
                emit_go   = 1'b1;
                emit_kind = fupc_pkg::KIND_WRITE;
                emit_code = fupc_pkg::CODE_START_OK;
                emit_addr = exp_reg + {24'b0, k_reg};
                emit_word = sh_reg;
                emit_last = 1'b0;
                emit_nxt  = S_PG_NEXT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_code_next  = res_code_reg;
                    out_addr_next  = res_addr_reg;
                    out_word_next  = res_word_reg;
                    out_wait_next  = res_wait_reg;
                    out_last_next  = res_last_reg;
                    state_next     = nxt_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fetch_go)
        begin
            rd_addr_next = fetch_addr;
            remain_next  = fetch_n;
            pend_next    = 1'b0;
            le_next      = fetch_le;
            ret_next     = fetch_ret;
            sh_next      = '0;
            state_next   = S_FETCH;
        end
        if (emit_go)
        begin
            res_kind_next = emit_kind;
            res_code_next = emit_code;
            res_addr_next = emit_addr;
            res_word_next = emit_word;
            res_wait_next = emit_wait;
            res_last_next = emit_last;
            nxt_next      = emit_nxt;
            state_next    = S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            nxt_reg        <= S_IDLE;
            phase_reg      <= PH_START;
            remain_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            app_start_reg  <= fupc_pkg::APP_START_RST;
            flash_size_reg <= fupc_pkg::FLASH_SIZE_RST;
            exp_reg        <= '0;
            end_reg        <= '0;
            wait_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            nxt_reg        <= nxt_next;
            phase_reg      <= phase_next;
            remain_reg     <= remain_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            app_start_reg  <= app_start_next;
            flash_size_reg <= flash_size_next;
            exp_reg        <= exp_next;
            end_reg        <= end_next;
            wait_reg       <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        le_reg        <= le_next;
        sh_reg        <= sh_next;
        job_len_reg   <= job_len_next;
        job_sum_reg   <= job_sum_next;
        size_reg      <= size_next;
        cnt_reg       <= cnt_next;
        k_reg         <= k_next;
        res_kind_reg  <= res_kind_next;
        res_code_reg  <= res_code_next;
        res_addr_reg  <= res_addr_next;
        res_word_reg  <= res_word_next;
        res_wait_reg  <= res_wait_next;
        res_last_reg  <= res_last_next;
        out_kind_reg  <= out_kind_next;
        out_code_reg  <= out_code_next;
        out_addr_reg  <= out_addr_next;
        out_word_reg  <= out_word_next;
        out_wait_reg  <= out_wait_next;
        out_last_reg  <= out_last_next;
    end

endmodule

>>> rtl/core/firmware_update_packet_checker_core.sv
// Timing: a closing beat, a timeout or a beat while halted queues a job, popped the next
// cycle; the back end reads the packet store one byte at a time, and each result is decided
// and then loaded into the output register. The input is held off until the job's last
// result is loaded, so no new beat is taken while a job is still being judged.
// Reset: async; clears framing, phase, queue; loads config defaults; store not cleared.
module firmware_update_packet_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    fupc_in_if.sink     rx,
    fupc_out_if.source  res,
    fupc_cfg_if.sink    cfg
);

    logic                          q_push;
    logic                          q_pop;
    logic                          q_empty;
    logic                          q_full;
    fupc_pkg::job_t                q_din;
    fupc_pkg::job_t                q_dout;
    fupc_pkg::status_t             st;
    logic [fupc_pkg::STORE_AW-1:0] rd_addr;
    logic [7:0]                    rd_data;

    fupc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .st      (st),
        .q_empty (q_empty),
        .q_push  (q_push),
        .q_din   (q_din),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fupc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .full  (q_full)
    );

    fupc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .res     (res),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_dout  (q_dout),
        .q_pop   (q_pop),
        .st      (st),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from empty queue");

    a_halt_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && st.halted) |-> (q_din.kind == fupc_pkg::JOB_HALTED))
        else $error("non-halt job queued while halted");

    a_write_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.kind == fupc_pkg::KIND_WRITE)) |->
        ((res.code == fupc_pkg::CODE_START_OK) && (res.wait_time == 32'd0) && !res.last))
        else $error("malformed word write beat");

endmodule

>>> verif/tb_firmware_update_packet_checker_core.sv
// Testbench for firmware_update_packet_checker_core: drives packet bytes, timeouts and
// register writes, predicts every word write and verdict, and checks the result channel.
// Depends on fupc_pkg and the channel interfaces in fupc_ifs.sv.
`timescale 1ns / 1ps

module tb_firmware_update_packet_checker_core;
    import fupc_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 40;

    typedef enum logic [1:0] {
        ST_START   = 2'd0,
        ST_PROGRAM = 2'd1,
        ST_HALTED  = 2'd2
    } loader_phase_t;

    typedef struct packed {
        logic        kind;
        code_t       code;
        logic [31:0] address;
        logic [31:0] data_word;
        logic [31:0] wait_time;
        logic        last;
    } fw_result_t;

    logic clk;
    logic rst_n;

    fupc_in_if  rx_ch();
    fupc_out_if res_ch();
    fupc_cfg_if cfg_ch();

    firmware_update_packet_checker_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the loader state
    loader_phase_t m_phase;
    logic [7:0]    m_idx;
    logic [7:0]    m_len;
    logic [7:0]    m_store [STORE_BYTES];
    logic [31:0]   m_expect_addr;
    logic [31:0]   m_end_addr;
    logic [31:0]   m_wait;
    logic [15:0]   m_sum;
    logic [23:0]   m_app_start;
    logic [24:0]   m_flash_size;

    fw_result_t beat_outcomes [$];
    fw_result_t packet_outcomes [$];
    fw_result_t head;
    fw_result_t seen;

    int err_count;
    int beats_sent;
    int burst_left;
    int image_bytes;
    int cycle_count;
    int ready_mode;
    int ready_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, packet_outcomes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count = err_count + 1;
        if (err_count <= 30)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic logic [31:0] store_be32(input int at);
        return {m_store[at], m_store[at + 1], m_store[at + 2], m_store[at + 3]};
    endfunction

    task automatic add_outcome(input logic kind, input code_t code, input logic [31:0] addr,
                               input logic [31:0] word, input logic [31:0] wt);
        fw_result_t r;
        r.kind      = kind;
        r.code      = code;
        r.address   = addr;
        r.data_word = word;
        r.wait_time = wt;
        r.last      = 1'b0;
        beat_outcomes.push_back(r);
    endtask

    // Advance the shadow state by one accepted beat and queue what it causes.
    task automatic track_beat(input logic op, input logic [7:0] b);
        logic        closed;
        logic [31:0] xfer_size;
        logic [32:0] image_end;
        logic [31:0] addr;
        logic [7:0]  cnt;
        logic [15:0] csum;
        int          p;
        closed = 1'b0;
        beat_outcomes.delete();
        if (m_phase == ST_HALTED)
        begin
            m_idx = 8'd0;
            add_outcome(KIND_VERDICT, CODE_HALTED, 32'd0, 32'd0, 32'd0);
        end
        else if (op)
        begin
            m_idx = 8'd0;
            if (m_phase == ST_START)
            begin
                m_phase = ST_HALTED;
                add_outcome(KIND_VERDICT, CODE_BOOT_APP, 32'd0, 32'd0, 32'd0);
            end
            else
                add_outcome(KIND_VERDICT, CODE_TMO_IGN, 32'd0, 32'd0, 32'd0);
        end
        else if (m_idx == 8'd0)
        begin
            m_len      = b;
            m_store[0] = b;
            m_sum      = 16'd0;
            if (b == 8'd0)
                closed = 1'b1;
            else
                m_idx = 8'd1;
        end
        else
        begin
            if (m_idx < STORE_BYTES)
                m_store[m_idx] = b;
            m_sum = m_sum + b;
            if (m_idx == m_len)
            begin
                closed = 1'b1;
                m_idx  = 8'd0;
            end
            else
                m_idx = m_idx + 8'd1;
        end

        if (closed && m_phase == ST_START)
        begin
            if (m_len == 8'd0)
            begin
                m_phase = ST_HALTED;
                add_outcome(KIND_VERDICT, CODE_BOOT_APP, 32'd0, 32'd0, 32'd0);
            end
            else if (m_len == START_LEN && m_store[1] == START_CMD && m_sum[7:0] == 8'd0)
            begin
                xfer_size = store_be32(SIZE_OFS);
                image_end = {1'b0, xfer_size} + m_app_start;
                m_wait    = store_be32(WAIT_OFS);
                if (image_end > m_flash_size)
                begin
                    m_phase = ST_HALTED;
                    add_outcome(KIND_VERDICT, CODE_TOO_LARGE, xfer_size, 32'd0, m_wait);
                end
                else
                begin
                    m_end_addr    = image_end[31:0];
                    m_expect_addr = {8'd0, m_app_start};
                    add_outcome(KIND_VERDICT, CODE_START_OK, xfer_size, 32'd0, m_wait);
                    if (m_expect_addr >= m_end_addr)
                    begin
                        m_phase = ST_HALTED;
                        add_outcome(KIND_VERDICT, CODE_DONE, 32'd0, 32'd0, 32'd0);
                    end
                    else
                        m_phase = ST_PROGRAM;
                end
            end
            else
            begin
                m_phase = ST_HALTED;
                add_outcome(KIND_VERDICT, CODE_START_BAD, 32'd0, 32'd0, 32'd0);
            end
        end
        else if (closed)
        begin
            if (!(m_len > HDR_LEN && m_len < STORE_BYTES))
                add_outcome(KIND_VERDICT, CODE_BAD_LEN, 32'd0, 32'd0, 32'd0);
            else
            begin
                addr = store_be32(ADDR_OFS);
                cnt  = m_store[CNT_OFS];
                // trailer counts as a big-endian word, not as two bytes
                csum = m_sum - m_store[m_len - 1] - m_store[m_len]
                       + {m_store[m_len - 1], m_store[m_len]};
                if (addr > m_expect_addr)
                    add_outcome(KIND_VERDICT, CODE_NACK_GAP, 32'd0, 32'd0, 32'd0);
                else if (addr < m_expect_addr)
                    add_outcome(KIND_VERDICT, CODE_DUPLICATE, 32'd0, 32'd0, 32'd0);
                else if (csum != 16'd0)
                    add_outcome(KIND_VERDICT, CODE_NACK_CSUM, 32'd0, 32'd0, 32'd0);
                else if (cnt[1:0] != 2'd0 || cnt > MAX_DATA_BYTES || cnt > m_len - HDR_LEN)
                    add_outcome(KIND_VERDICT, CODE_NACK_LEN, 32'd0, 32'd0, 32'd0);
                else
                begin
                    for (p = 0; p < cnt; p += 4)
                        add_outcome(KIND_WRITE, CODE_START_OK, m_expect_addr + p,
                                    {m_store[DATA_OFS + p + 3], m_store[DATA_OFS + p + 2],
                                     m_store[DATA_OFS + p + 1], m_store[DATA_OFS + p]},
                                    32'd0);
                    m_expect_addr = m_expect_addr + cnt;
                    if (m_expect_addr >= m_end_addr)
                    begin
                        m_phase = ST_HALTED;
                        add_outcome(KIND_VERDICT, CODE_DONE, 32'd0, 32'd0, 32'd0);
                    end
                    else
                        add_outcome(KIND_VERDICT, CODE_PROGRAMMED, 32'd0, 32'd0, 32'd0);
                end
            end
        end

        if (beat_outcomes.size() > 0)
            beat_outcomes[beat_outcomes.size() - 1].last = 1'b1;
        foreach (beat_outcomes[i])
            packet_outcomes.push_back(beat_outcomes[i]);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.kind      = res_ch.kind;
            seen.code      = code_t'(res_ch.code);
            seen.address   = res_ch.address;
            seen.data_word = res_ch.data_word;
            seen.wait_time = res_ch.wait_time;
            seen.last      = res_ch.last;
            if (packet_outcomes.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d code %0d addr %h",
                                          seen.kind, seen.code, seen.address));
            else
            begin
                head = packet_outcomes.pop_front();
                if (seen !== head)
                    report_mismatch($sformatf(
                        "got k%0d c%0d a%h d%h w%h l%0d, want k%0d c%0d a%h d%h w%h l%0d",
                        seen.kind, seen.code, seen.address, seen.data_word, seen.wait_time,
                        seen.last, head.kind, head.code, head.address, head.data_word,
                        head.wait_time, head.last));
            end
        end
    end

    // receiver stalls: segments of always-ready, random, sparse or fully stalled
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = $urandom_range(0, 4);
            ready_hold = $urandom_range(4, 40);
        end
        else
            ready_hold = ready_hold - 1;
        case (ready_mode)
            0, 1:    res_ch.ready <= 1'b1;
            2:       res_ch.ready <= 1'($urandom_range(0, 1));
            3:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= 1'b0;
        endcase
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_beat(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.op        <= op;
        rx_ch.data_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        track_beat(op, b);
        beats_sent = beats_sent + 1;
        burst_left = burst_left - 1;
        @(negedge clk);
    endtask

    // Hold off the input until every outstanding result has come back.
    task automatic drain_outcomes();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (packet_outcomes.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [24:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_APP_START)
            m_app_start = val[23:0];
        else
            m_flash_size = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Program packet: address, count, ndata bytes, checksum; cut_at >= 0 sends that many
    // bytes and then a timeout instead of the rest.
    task automatic send_program_packet(input logic [31:0] addr, input logic [7:0] cnt,
                                       input int ndata, input logic [15:0] csum_flip,
                                       input int cut_at);
        logic [7:0]  pkt [$];
        logic [15:0] sum;
        int          i;
        sum = 16'd0;
        pkt.push_back(8'(7 + ndata));
        for (i = 3; i >= 0; i--)
            pkt.push_back(addr[8 * i +: 8]);
        pkt.push_back(cnt);
        for (i = 0; i < ndata; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
        for (i = 1; i < pkt.size(); i++)
            sum = sum + pkt[i];
        sum = (16'd0 - sum) ^ csum_flip;
        pkt.push_back(sum[15:8]);
        pkt.push_back(sum[7:0]);
        for (i = 0; i < pkt.size() && (cut_at < 0 || i < cut_at); i++)
            send_beat(1'b0, pkt[i]);
        if (cut_at >= 0)
            send_beat(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_raw_packet(input int len);
        int i;
        send_beat(1'b0, 8'(len));
        for (i = 0; i < len; i++)
            send_beat(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_config_extremes();
        logic [23:0] base;
        write_register(CFG_APP_START, {1'b1, 24'hFF_FFFF});
        write_register(CFG_FLASH_SIZE, 25'd1024);
        write_register(CFG_APP_START, 25'd0);
        write_register(CFG_FLASH_SIZE, 25'h100_0000);
        base        = 24'($urandom_range(1024, 24'hFF_0000));
        image_bytes = $urandom_range(100, 128);
        write_register(CFG_APP_START, {1'($urandom_range(0, 1)), base});
        // image end landing exactly on the flash end is still accepted
        if ($urandom_range(0, 1))
            write_register(CFG_FLASH_SIZE, 25'(base + image_bytes));
    endtask

    task automatic test_start_packet();
        logic [7:0]  pkt [$];
        logic [31:0] wait_us;
        logic [31:0] xfer;
        logic [7:0]  chk;
        int          i;
        wait_us = $urandom();
        xfer    = image_bytes;
        chk     = 8'd0;
        pkt.push_back(START_LEN);
        pkt.push_back(START_CMD);
        for (i = 3; i >= 0; i--)
            pkt.push_back(xfer[8 * i +: 8]);
        for (i = 3; i >= 0; i--)
            pkt.push_back(wait_us[8 * i +: 8]);
        for (i = 1; i < pkt.size(); i++)
            chk = chk - pkt[i];
        pkt.push_back(chk);
        foreach (pkt[j])
            send_beat(1'b0, pkt[j]);
    endtask

    task automatic test_program_directed();
        send_program_packet(m_expect_addr, 8'd4, 4, 16'h0000, -1);
        send_program_packet(m_expect_addr - 4, 8'd4, 4, 16'h0000, -1);
        send_program_packet(m_expect_addr + 4, 8'd4, 4, 16'h0000, -1);
        send_program_packet(m_expect_addr | 32'h8000_0000, 8'd4, 4, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd4, 4, 16'h0001, -1);
        send_program_packet(m_expect_addr, 8'd4, 4, 16'h8000, -1);
        send_program_packet(m_expect_addr, 8'd2, 4, 16'h0000, -1);
        // count claims more data than the packet carries
        send_program_packet(m_expect_addr, 8'd8, 4, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd36, 8, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'hFC, 8, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd0, 1, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd32, 32, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd4, 7, 16'h0000, -1);
        send_program_packet(m_expect_addr, 8'd0, 0, 16'h0000, -1);
        send_raw_packet(0);
        send_raw_packet(40);
        send_beat(1'b1, 8'hFF);
        send_program_packet(m_expect_addr, 8'd4, 4, 16'h0000, 6);
        send_program_packet(m_expect_addr, 8'd4, 4, 16'h0000, -1);
    endtask

    task automatic test_program_random(input int beat_budget);
        int         stop_at;
        int         pick;
        int         nd;
        int         k;
        logic [7:0] cnt;
        stop_at = beats_sent + beat_budget;
        while (m_phase == ST_PROGRAM && beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            nd   = $urandom_range(1, 32);
            if (pick < 55)
            begin
                k  = $urandom_range(0, 8);
                nd = 4 * k + $urandom_range(0, 32 - 4 * k);
                if (nd == 0)
                    nd = 1;
                send_program_packet(m_expect_addr, 8'(4 * k), nd, 16'h0000, -1);
            end
            else if (pick < 63)
                send_program_packet(m_expect_addr - 4 * $urandom_range(1, 8), 8'd4,
                                    nd < 4 ? 4 : nd, 16'h0000, -1);
            else if (pick < 69)
                send_program_packet(m_expect_addr + $urandom_range(1, 64), 8'd4,
                                    nd < 4 ? 4 : nd, 16'h0000, -1);
            else if (pick < 75)
                send_program_packet(m_expect_addr, 8'd4, nd < 4 ? 4 : nd,
                                    16'($urandom_range(1, 65535)), -1);
            else if (pick < 81)
            begin
                cnt = 8'($urandom_range(0, 255));
                if (cnt[1:0] == 2'd0 && cnt <= MAX_DATA_BYTES && cnt <= nd)
                    cnt[0] = 1'b1;
                send_program_packet(m_expect_addr, cnt, nd, 16'h0000, -1);
            end
            else if (pick < 86)
                send_raw_packet($urandom_range(0, 1) ? $urandom_range(1, 7)
                                                     : $urandom_range(40, 80));
            else if (pick < 91)
                send_program_packet(m_expect_addr, 8'd4, nd, 16'h0000,
                                    $urandom_range(1, 7 + nd));
            else if (pick < 95)
                send_beat(1'b1, 8'($urandom_range(0, 255)));
            else
                send_raw_packet($urandom_range(1, 39));
        end
    endtask

    task automatic test_config_while_programming();
        drain_outcomes();
        write_register(CFG_FLASH_SIZE, 25'($urandom_range(1024, 25'h100_0000)));
        write_register(CFG_APP_START, 25'($urandom_range(0, 25'h1FF_FFFF)));
    endtask

    task automatic test_finish_image();
        while (m_phase == ST_PROGRAM)
            send_program_packet(m_expect_addr, 8'd32, 32, 16'h0000, -1);
    endtask

    task automatic test_halted_inputs();
        int i;
        drain_outcomes();
        write_register(CFG_APP_START, {1'b0, 24'hFF_FFFF});
        write_register(CFG_FLASH_SIZE, 25'd1024);
        for (i = 0; i < 12; i++)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        rx_ch.valid      = 1'b0;
        rx_ch.op         = 1'b0;
        rx_ch.data_byte  = 8'd0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_APP_START;
        cfg_ch.wdata     = 25'd0;
        res_ch.ready     = 1'b0;
        err_count        = 0;
        beats_sent       = 0;
        burst_left       = 0;
        cycle_count      = 0;
        ready_mode       = 0;
        ready_hold       = 0;
        m_phase          = ST_START;
        m_idx            = 8'd0;
        m_len            = 8'd0;
        m_expect_addr    = 32'd0;
        m_end_addr       = 32'd0;
        m_wait           = 32'd0;
        m_sum            = 16'd0;
        m_app_start      = APP_START_RST;
        m_flash_size     = FLASH_SIZE_RST;
        foreach (m_store[i])
            m_store[i] = 8'd0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_config_extremes();
        test_start_packet();
        test_program_directed();
        test_program_random(40);
        test_config_while_programming();
        test_program_random(30);
        test_finish_image();
        test_halted_inputs();

        drain_outcomes();
        if (packet_outcomes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", packet_outcomes.size()));
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
